/* design/debounced_toggle_switch_bank_macros.svh */
// Assertion macros for the debounced toggle switch bank checker.
// No dependencies; included by the checker file.
`ifndef DEBOUNCED_TOGGLE_SWITCH_BANK_MACROS_SVH
`define DEBOUNCED_TOGGLE_SWITCH_BANK_MACROS_SVH

// Same-cycle implication, reset as disable condition.
`define DTSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset as disable condition.
`define DTSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dtsb_pkg.sv */
// Shared types and constants for the debounced toggle switch bank.
// No dependencies; used by the interfaces and the bank's modules.
package dtsb_pkg;

   localparam int SWITCH_COUNT      = 8;
   localparam int INDEX_WIDTH       = 3;
   localparam int TIME_WIDTH        = 32;
   localparam int CFG_WIDTH         = 16;
   localparam int CSR_INDEX_WIDTH   = 4;

   localparam logic [CFG_WIDTH-1:0] BOUNCE_GAP_MS_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_MS_RESET = 16'd2000;

   // Pin level: buttons are active low.
   localparam logic LEVEL_PRESSED = 1'b0;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BOUNCE_GAP_MS = 4'd0,
      CSR_LONG_PRESS_MS = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] bounce_gap_ms;
      logic [CFG_WIDTH-1:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] button_id;
      logic                   pin_level;
      logic [TIME_WIDTH-1:0]  now_ms;
   } event_type;

   // Input stage contents handed to the core.
   typedef struct packed {
      logic      valid;
      event_type item;
   } staged_type;

endpackage

/* design/dtsb_req_if.sv */
// Request channel: one switch edge event per transaction.
// Depends on dtsb_pkg.
interface dtsb_req_if;
   logic                             valid;
   logic                             ready;
   logic [dtsb_pkg::INDEX_WIDTH-1:0] button_id;
   logic                             pin_level;
   logic [dtsb_pkg::TIME_WIDTH-1:0]  now_ms;

   modport source (output valid, button_id, pin_level, now_ms, input ready);
   modport sink   (input valid, button_id, pin_level, now_ms, output ready);
endinterface

/* design/dtsb_rsp_if.sv */
// Response channel: one result per switch edge event.
// Depends on dtsb_pkg.
interface dtsb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dtsb_pkg::INDEX_WIDTH-1:0] event_index;
   logic                             accepted;
   logic                             toggled;
   logic                             switch_on;

   modport source (output valid, event_index, accepted, toggled, switch_on, input ready);
   modport sink   (input valid, event_index, accepted, toggled, switch_on, output ready);
endinterface

/* design/debounced_toggle_switch_bank.sv */
// Top level of the debounced toggle switch bank.
// Depends on dtsb_pkg, dtsb_req_if, dtsb_rsp_if, dtsb_csr, dtsb_in_stage, dtsb_core.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        button_id, pin_level, now_ms
//   rsp_chan  out  valid/ready        event_index, accepted, toggled, switch_on
//   csr_*     in   write enable only  csr_index, csr_write_data (16 bit)
//
// Flow: one transaction per cycle while rsp_chan.ready stays high; a request
//   passes through the input register, then the result register.
// State read, decision and state write all happen in the core stage, so an
//   event sees every update of the event before it with no forwarding.
// Reset (synchronous): empties both stages, clears per-switch times and
//   toggle bits, loads debounce 50 ms and long press 2000 ms.
// Stalls: rsp_chan.ready low holds the result; an empty input stage still
//   takes one more transaction and then drops req_chan.ready.
module debounced_toggle_switch_bank (
   input  logic                                 clock,
   input  logic                                 reset,
   dtsb_req_if.sink                             req_chan,
   dtsb_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [dtsb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dtsb_pkg::CFG_WIDTH-1:0]       csr_write_data
);

   dtsb_pkg::cfg_type    cfg;
   dtsb_pkg::staged_type staged;
   logic                 pop;

   // Configuration registers; user must write only while bank is idle, not enforced.
   dtsb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Input register; frees itself whenever the core takes its event.
   dtsb_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .staged   (staged)
   );

   // Debounce check, toggle update and result register.
   dtsb_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .staged   (staged),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* design/dtsb_csr.sv */
// Configuration registers: debounce and long-press times.
// Depends on dtsb_pkg.
module dtsb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dtsb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dtsb_pkg::CFG_WIDTH-1:0]       csr_write_data,
   output dtsb_pkg::cfg_type                    cfg
);

   dtsb_pkg::cfg_type cfg_ff;
   dtsb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dtsb_pkg::CSR_BOUNCE_GAP_MS: begin
               cfg_in.bounce_gap_ms = csr_write_data;
            end
            dtsb_pkg::CSR_LONG_PRESS_MS: begin
               cfg_in.long_press_ms = csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_gap_ms <= dtsb_pkg::BOUNCE_GAP_MS_RESET;
         cfg_ff.long_press_ms <= dtsb_pkg::LONG_PRESS_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/dtsb_in_stage.sv */
// Input register for request transactions.
// Depends on dtsb_pkg and dtsb_req_if.
module dtsb_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   dtsb_req_if.sink             req_chan,
   input  logic                 pop,
   output dtsb_pkg::staged_type staged
);

   logic                valid_ff;
   logic                valid_in;
   dtsb_pkg::event_type item_ff;
   logic                load;

   // Free slot, or the held event moves on this cycle.
   assign req_chan.ready = !valid_ff || pop;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.button_id <= req_chan.button_id;
         item_ff.pin_level <= req_chan.pin_level;
         item_ff.now_ms    <= req_chan.now_ms;
      end
   end

   assign staged.valid = valid_ff;
   assign staged.item  = item_ff;

endmodule

/* design/dtsb_core.sv */
// Per-switch state, debounce and toggle decision, result register.
// Depends on dtsb_pkg and dtsb_rsp_if.
module dtsb_core (
   input  logic                 clock,
   input  logic                 reset,
   input  dtsb_pkg::cfg_type    cfg,
   input  dtsb_pkg::staged_type staged,
   output logic                 pop,
   dtsb_rsp_if.source           rsp_chan
);

   logic [dtsb_pkg::TIME_WIDTH-1:0]   last_time_ff  [dtsb_pkg::SWITCH_COUNT];
   logic [dtsb_pkg::TIME_WIDTH-1:0]   press_time_ff [dtsb_pkg::SWITCH_COUNT];
   logic [dtsb_pkg::SWITCH_COUNT-1:0] toggle_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [dtsb_pkg::INDEX_WIDTH-1:0] rsp_index_ff;
   logic                             rsp_accepted_ff;
   logic                             rsp_toggled_ff;
   logic                             rsp_on_ff;

   logic [dtsb_pkg::INDEX_WIDTH-1:0] sw;
   logic [dtsb_pkg::TIME_WIDTH-1:0]  since_last;
   logic [dtsb_pkg::TIME_WIDTH-1:0]  held_for;
   logic                             in_range;
   logic                             passed;
   logic                             flip;
   logic                             on_after;
   logic                             commit;

   assign pop = staged.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign sw  = staged.item.button_id;

   always_comb begin
      in_range   = (32'(sw) < dtsb_pkg::SWITCH_COUNT);
      since_last = staged.item.now_ms - last_time_ff[sw];
      held_for   = staged.item.now_ms - press_time_ff[sw];
      passed     = in_range &&
                   (since_last > {16'd0, cfg.bounce_gap_ms});
      flip       = passed &&
                   ((staged.item.pin_level == dtsb_pkg::LEVEL_PRESSED) ||
                    (held_for >= {16'd0, cfg.long_press_ms}));
      on_after   = in_range && (toggle_ff[sw] ^ flip);
      commit     = pop && passed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_ff <= '0;
         for (int i = 0; i < dtsb_pkg::SWITCH_COUNT; i++) begin
            last_time_ff[i]  <= '0;
            press_time_ff[i] <= '0;
         end
      end else if (commit) begin
         last_time_ff[sw] <= staged.item.now_ms;
         if (staged.item.pin_level == dtsb_pkg::LEVEL_PRESSED) begin
            press_time_ff[sw] <= staged.item.now_ms;
         end
         toggle_ff[sw] <= toggle_ff[sw] ^ flip;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_index_ff    <= sw;
         rsp_accepted_ff <= passed;
         rsp_toggled_ff  <= flip;
         rsp_on_ff       <= on_after;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_index = rsp_index_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.toggled     = rsp_toggled_ff;
   assign rsp_chan.switch_on   = rsp_on_ff;

endmodule

/* design/dtsb_checker.sv */
// Port-level checks for the debounced toggle switch bank, bound to the top.
// Depends on debounced_toggle_switch_bank_macros.svh.
`include "debounced_toggle_switch_bank_macros.svh"

module dtsb_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_accepted,
   input logic rsp_toggled,
   input logic rsp_switch_on,
   input logic [2:0] rsp_event_index
);

   `DTSB_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid && req_ready, "reset did not empty the bank")
   `DTSB_ASSERT_NOW(a_reject_no_flip, clock, reset, rsp_valid && !rsp_accepted, !rsp_toggled, "rejected event toggled")
   `DTSB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `DTSB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_event_index) && $stable(rsp_accepted) && $stable(rsp_toggled) && $stable(rsp_switch_on), "result changed while stalled")

endmodule

bind debounced_toggle_switch_bank dtsb_checker u_dtsb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_accepted    (rsp_chan.accepted),
   .rsp_toggled     (rsp_chan.toggled),
   .rsp_switch_on   (rsp_chan.switch_on),
   .rsp_event_index (rsp_chan.event_index)
);

/* test/debounced_toggle_switch_bank_tb.sv */
// Self-checking testbench for debounced_toggle_switch_bank: directed and random edge events.
// Depends on dtsb_pkg, dtsb_req_if, dtsb_rsp_if and the design top level.
module debounced_toggle_switch_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected result transaction, field for field as on rsp_chan.
   typedef struct packed {
      logic [dtsb_pkg::INDEX_WIDTH-1:0] event_index;
      logic                             accepted;
      logic                             toggled;
      logic                             switch_on;
   } switch_outcome_type;

   localparam int SEGMENT_EVENTS = 325;   // 3 idle phases x 2 settings x 325 = 1950
   localparam int SETTLE_CYCLES  = 4;     // two-stage pipe plus margin

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_write_enable;
   logic [dtsb_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [dtsb_pkg::CFG_WIDTH-1:0]       csr_write_data;

   dtsb_req_if req_chan ();
   dtsb_rsp_if rsp_chan ();

   debounced_toggle_switch_bank i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the switch bank: per-switch times, toggle bits and the
   // two timing registers as last written.
   logic [dtsb_pkg::TIME_WIDTH-1:0] bank_last_event  [dtsb_pkg::SWITCH_COUNT];
   logic [dtsb_pkg::TIME_WIDTH-1:0] bank_press_start [dtsb_pkg::SWITCH_COUNT];
   logic                            bank_toggle      [dtsb_pkg::SWITCH_COUNT];
   logic [dtsb_pkg::CFG_WIDTH-1:0]  bounce_gap_limit;
   logic [dtsb_pkg::CFG_WIDTH-1:0]  long_press_limit;

   switch_outcome_type expected_results [$];
   switch_outcome_type oldest_result;
   int                 failures;

   // Percent of cycles in which each side holds off.
   int send_idle_pct;
   int recv_idle_pct;

   always #10 clock = ~clock;

   // Everything an edge event does to the bank, in the order the block does it:
   // debounce test on the modulo-2^32 time since the last accepted event, then
   // press/release handling, then the toggle flip.
   function automatic switch_outcome_type predict_switch_event(
         logic [dtsb_pkg::INDEX_WIDTH-1:0] sw,
         logic                             level,
         logic [dtsb_pkg::TIME_WIDTH-1:0]  now);
      switch_outcome_type              outcome;
      logic [dtsb_pkg::TIME_WIDTH-1:0] since_last;
      logic [dtsb_pkg::TIME_WIDTH-1:0] held_for;
      outcome             = '0;
      outcome.event_index = sw;
      if (int'(sw) < dtsb_pkg::SWITCH_COUNT) begin
         since_last = now - bank_last_event[sw];
         if (since_last > {16'd0, bounce_gap_limit}) begin
            outcome.accepted    = 1'b1;
            bank_last_event[sw] = now;
            if (level == dtsb_pkg::LEVEL_PRESSED) begin
               bank_press_start[sw] = now;
               outcome.toggled      = 1'b1;
            end else begin
               // a release measures from the stored press time, even if no
               // press was ever accepted (then it is still zero)
               held_for = now - bank_press_start[sw];
               if (held_for >= {16'd0, long_press_limit})
                  outcome.toggled = 1'b1;
            end
            if (outcome.toggled)
               bank_toggle[sw] = ~bank_toggle[sw];
         end
         outcome.switch_on = bank_toggle[sw];
      end
      return outcome;
   endfunction

   // Drives one edge event and waits for its handshake; valid stays high
   // afterwards so back-to-back transactions need no bubble.
   task automatic send_event(logic [dtsb_pkg::INDEX_WIDTH-1:0] sw, logic level,
                             logic [dtsb_pkg::TIME_WIDTH-1:0] now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.button_id <= sw;
      req_chan.pin_level <= level;
      req_chan.now_ms    <= now;
      do
         @(posedge clock);
      while (!req_chan.ready);
      expected_results.push_back(predict_switch_event(sw, level, now));
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic drain_bank;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called with the pipe empty.
   task automatic write_register(dtsb_pkg::csr_index_type idx,
                                 logic [dtsb_pkg::CFG_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         dtsb_pkg::CSR_BOUNCE_GAP_MS: bounce_gap_limit = value;
         dtsb_pkg::CSR_LONG_PRESS_MS: long_press_limit = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(logic [dtsb_pkg::CFG_WIDTH-1:0] bounce_gap,
                             logic [dtsb_pkg::CFG_WIDTH-1:0] long_press);
      drain_bank();
      write_register(dtsb_pkg::CSR_BOUNCE_GAP_MS, bounce_gap);
      write_register(dtsb_pkg::CSR_LONG_PRESS_MS, long_press);
   endtask

   // Reset values: 50 ms debounce, 2 s long press, all times zero. Events at
   // or below 50 ms are bounces; a release with no press on record measures
   // from time zero.
   task automatic test_first_events_after_reset;
      send_event(3'd0, 1'b0, 32'd0);
      send_event(3'd0, 1'b0, 32'd50);
      send_event(3'd0, 1'b0, 32'd51);
      send_event(3'd1, 1'b1, 32'd3000);
      send_event(3'd2, 1'b1, 32'd1000);
   endtask

   // Strictly-greater debounce edge and at-or-above long-press edge.
   task automatic test_debounce_and_long_press;
      set_timing(16'd100, 16'd500);
      send_event(3'd3, 1'b0, 32'd10000);
      send_event(3'd3, 1'b1, 32'd10100);   // exactly the debounce time: bounce
      send_event(3'd3, 1'b1, 32'd10101);   // short press, toggle kept
      send_event(3'd3, 1'b0, 32'd20000);
      send_event(3'd3, 1'b1, 32'd20499);   // one short of long press
      send_event(3'd4, 1'b0, 32'd30000);
      send_event(3'd4, 1'b1, 32'd30500);   // exactly long press: undone
   endtask

   // Both registers at zero, then both at full scale.
   task automatic test_register_extremes;
      set_timing(16'd0, 16'd0);
      send_event(3'd5, 1'b0, 32'd40000);
      send_event(3'd5, 1'b1, 32'd40000);   // zero elapsed is still a bounce
      send_event(3'd5, 1'b1, 32'd40001);
      set_timing(16'hFFFF, 16'hFFFF);
      send_event(3'd6, 1'b0, 32'd100000);
      send_event(3'd6, 1'b1, 32'd165535);
      send_event(3'd6, 1'b1, 32'd165536);
   endtask

   // Millisecond counter wrapping through 2^32 between press and release.
   task automatic test_time_wrap;
      set_timing(dtsb_pkg::BOUNCE_GAP_MS_RESET, dtsb_pkg::LONG_PRESS_MS_RESET);
      send_event(3'd7, 1'b0, 32'hFFFF_FFF0);
      send_event(3'd7, 1'b1, 32'h0000_0030);
      send_event(3'd7, 1'b0, 32'hFFFF_FFFF);
      send_event(3'd7, 1'b1, 32'h0000_07CF);   // held exactly 2000 ms across the wrap
   endtask

   // Mostly proper press/release sequences on a moving clock, with bounce
   // bursts that land inside the debounce window, repeated levels and the
   // odd jump to an arbitrary time. Three idle mixes, two timing settings
   // each.
   task automatic test_random_traffic;
      logic [dtsb_pkg::TIME_WIDTH-1:0]  cursor;
      logic [dtsb_pkg::INDEX_WIDTH-1:0] sw;
      logic                             level;
      logic                             last_level [dtsb_pkg::SWITCH_COUNT];
      int                               sent;
      int                               burst;
      int                               roll;
      for (int i = 0; i < dtsb_pkg::SWITCH_COUNT; i++)
         last_level[i] = 1'b1;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 34; recv_idle_pct = 46; end
            1: begin send_idle_pct = 46; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 2; seg++) begin
            set_timing(16'($urandom_range(120)), 16'($urandom_range(3000)));
            cursor = (phase == 1 && seg == 0) ? 32'hFFFF_F000 : 32'($urandom);
            sent   = 0;
            while (sent < SEGMENT_EVENTS) begin
               sw    = 3'($urandom_range(dtsb_pkg::SWITCH_COUNT - 1));
               burst = ($urandom_range(99) < 25) ? $urandom_range(5, 2) : 1;
               roll  = $urandom_range(99);
               if (roll < 4)
                  cursor = 32'($urandom);
               else if (roll < 20)
                  cursor += 32'($urandom_range(5000));
               else
                  cursor += 32'($urandom_range(400));
               for (int k = 0; k < burst && sent < SEGMENT_EVENTS; k++) begin
                  if (k > 0)
                     cursor += 32'($urandom_range(30));
                  level          = ($urandom_range(99) < 85) ? ~last_level[sw] : last_level[sw];
                  last_level[sw] = level;
                  send_event(sw, level, cursor);
                  sent++;
               end
            end
         end
      end
   endtask

   // Receiver hold-off, redrawn every cycle.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Every result transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected (event_index %0d)",
                   rsp_chan.event_index);
            failures++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_chan.event_index !== oldest_result.event_index) begin
               $error("event_index: expected %0d, got %0d",
                      oldest_result.event_index, rsp_chan.event_index);
               failures++;
            end
            if (rsp_chan.accepted !== oldest_result.accepted) begin
               $error("accepted: expected %0d, got %0d",
                      oldest_result.accepted, rsp_chan.accepted);
               failures++;
            end
            if (rsp_chan.toggled !== oldest_result.toggled) begin
               $error("toggled: expected %0d, got %0d",
                      oldest_result.toggled, rsp_chan.toggled);
               failures++;
            end
            if (rsp_chan.switch_on !== oldest_result.switch_on) begin
               $error("switch_on: expected %0d, got %0d",
                      oldest_result.switch_on, rsp_chan.switch_on);
               failures++;
            end
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      req_chan.valid     = 1'b0;
      req_chan.button_id = '0;
      req_chan.pin_level = 1'b1;
      req_chan.now_ms    = '0;
      rsp_chan.ready     = 1'b0;
      failures           = 0;
      send_idle_pct      = 34;
      recv_idle_pct      = 46;
      bounce_gap_limit   = dtsb_pkg::BOUNCE_GAP_MS_RESET;
      long_press_limit   = dtsb_pkg::LONG_PRESS_MS_RESET;
      for (int i = 0; i < dtsb_pkg::SWITCH_COUNT; i++) begin
         bank_last_event[i]  = '0;
         bank_press_start[i] = '0;
         bank_toggle[i]      = 1'b0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_events_after_reset();
      test_debounce_and_long_press();
      test_register_extremes();
      test_time_wrap();
      test_random_traffic();

      drain_bank();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run of about 2000 transactions.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
